@@ sv/gpioei_pkg.sv @@
// ----------------------------------------------------------------------------
// gpioei_pkg: shared types and constants of the GPIO port
// Operation codes, register indexes, interrupt codes, the result word type
// and helpers that build the pin masks from the pin count.
// ----------------------------------------------------------------------------
package gpioei_pkg;

  localparam int PIN_COUNT_DEF = 32;
  localparam int MAX_PINS      = 32;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_DATA   = 3'd0;
  localparam logic [2:0] REG_DIR    = 3'd1;
  localparam logic [2:0] REG_ICR_LO = 3'd2;
  localparam logic [2:0] REG_ICR_HI = 3'd3;
  localparam logic [2:0] REG_MASK   = 3'd4;
  localparam logic [2:0] REG_STATUS = 3'd5;
  localparam logic [2:0] REG_EDGE   = 3'd6;

  // Per-pin interrupt codes
  localparam logic [1:0] ICR_LOW  = 2'd0;
  localparam logic [1:0] ICR_HIGH = 2'd1;
  localparam logic [1:0] ICR_RISE = 2'd2;
  localparam logic [1:0] ICR_FALL = 2'd3;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] pad_drive;
    logic [31:0] pad_enable;
    logic        irq_out;
  } res_t;

  function automatic logic [31:0] pin_mask(input int pins);
    logic [31:0] m;
    m = '0;
    for (int p = 0; p < MAX_PINS; p++) begin
      if (p < pins) m[p] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [63:0] cfg_mask(input int pins);
    logic [63:0] m;
    m = '0;
    for (int p = 0; p < MAX_PINS; p++) begin
      if (p < pins) m[2*p +: 2] = 2'b11;
    end
    return m;
  endfunction

endpackage

@@ sv/gpio_port_with_edge_interrupts.sv @@
// ----------------------------------------------------------------------------
// gpio_port_with_edge_interrupts: 32-pin GPIO port with interrupt detection
// Register file, pad sampling and interrupt status behind one command channel.
// ----------------------------------------------------------------------------
// Each input word is one command: a register read, a register write or a pad
// sample tick (in_opcode, in_reg_index, in_write_data, in_pad_levels). Every
// command gives exactly one result word: read data (zero unless a read), the
// output latch, the direction register and the masked interrupt line, all
// taken after the command's update.
// The result is registered, in the result register or, while a result is
// held, in the skid register. Throughput is one word per cycle while in_ready
// is high; the register update and the detection of all pins are a single
// level of logic between the input handshake and the result register.
// A two-entry output stage (result register plus skid register) keeps
// in_ready independent of out_ready: one more word is taken while a result
// waits, after which in_ready drops until the receiver takes a word.
// Synchronous reset clears the port registers (all pins inputs, low-level codes,
// no status) and empties the output stage.
// ----------------------------------------------------------------------------
module gpio_port_with_edge_interrupts #(
  parameter int PIN_COUNT = gpioei_pkg::PIN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_pad_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [31:0] out_pad_drive,
  output logic [31:0] out_pad_enable,
  output logic        out_irq_out
);

  localparam logic [31:0] PinMask = gpioei_pkg::pin_mask(PIN_COUNT);
  localparam logic [63:0] CfgMask = gpioei_pkg::cfg_mask(PIN_COUNT);

  logic [31:0] data_latch_r,  data_latch_nxt;
  logic [31:0] direction_r,   direction_nxt;
  logic [63:0] int_config_r,  int_config_nxt;
  logic [31:0] int_mask_r,    int_mask_nxt;
  logic [31:0] int_status_r,  int_status_nxt;
  logic [31:0] edge_select_r, edge_select_nxt;
  logic [31:0] last_pads_r,   last_pads_nxt;

  logic [31:0] pads;
  logic [31:0] hit;
  logic [31:0] rd;
  logic        accept;

  gpioei_pkg::res_t res;
  gpioei_pkg::res_t out_r, out_nxt;
  gpioei_pkg::res_t skid_r, skid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;

  assign pads = in_pad_levels & PinMask;

  gpioei_detect #(
    .PIN_COUNT (PIN_COUNT)
  ) u_detect (
    .pads        (pads),
    .last_pads   (last_pads_r),
    .int_config  (int_config_r),
    .edge_select (edge_select_r),
    .hit         (hit)
  );

  always_comb begin
    data_latch_nxt  = data_latch_r;
    direction_nxt   = direction_r;
    int_config_nxt  = int_config_r;
    int_mask_nxt    = int_mask_r;
    int_status_nxt  = int_status_r;
    edge_select_nxt = edge_select_r;
    last_pads_nxt   = last_pads_r;
    rd              = '0;
    case (in_opcode)
      gpioei_pkg::OP_READ: begin
        unique case (in_reg_index)
          // Output pins read back the latch, input pins the last sample.
          gpioei_pkg::REG_DATA:
            rd = (data_latch_r & direction_r) | (last_pads_r & ~direction_r);
          gpioei_pkg::REG_DIR:    rd = direction_r;
          gpioei_pkg::REG_ICR_LO: rd = int_config_r[31:0];
          gpioei_pkg::REG_ICR_HI: rd = int_config_r[63:32];
          gpioei_pkg::REG_MASK:   rd = int_mask_r;
          gpioei_pkg::REG_STATUS: rd = int_status_r;
          gpioei_pkg::REG_EDGE:   rd = edge_select_r;
          default:                rd = '0;
        endcase
      end
      gpioei_pkg::OP_WRITE: begin
        unique case (in_reg_index)
          gpioei_pkg::REG_DATA:   data_latch_nxt = in_write_data & PinMask;
          gpioei_pkg::REG_DIR:    direction_nxt = in_write_data & PinMask;
          gpioei_pkg::REG_ICR_LO:
            int_config_nxt = {int_config_r[63:32], in_write_data} & CfgMask;
          gpioei_pkg::REG_ICR_HI:
            int_config_nxt = {in_write_data, int_config_r[31:0]} & CfgMask;
          gpioei_pkg::REG_MASK:   int_mask_nxt = in_write_data & PinMask;
          gpioei_pkg::REG_STATUS: int_status_nxt = int_status_r & ~in_write_data;
          gpioei_pkg::REG_EDGE:   edge_select_nxt = in_write_data & PinMask;
          default: ;
        endcase
      end
      gpioei_pkg::OP_TICK: begin
        int_status_nxt = int_status_r | hit;
        last_pads_nxt  = pads;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.read_data  = rd;
    res.pad_drive  = data_latch_nxt;
    res.pad_enable = direction_nxt;
    res.irq_out    = |(int_status_nxt & int_mask_nxt);
  end

  assign in_ready = ~skid_valid_r;
  assign accept   = in_valid & in_ready;

  // Output stage: a new word goes to the result register when it is free or
  // being drained, otherwise into the skid register.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_ready) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_latch_r  <= '0;
      direction_r   <= '0;
      int_config_r  <= '0;
      int_mask_r    <= '0;
      int_status_r  <= '0;
      edge_select_r <= '0;
      last_pads_r   <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        data_latch_r  <= data_latch_nxt;
        direction_r   <= direction_nxt;
        int_config_r  <= int_config_nxt;
        int_mask_r    <= int_mask_nxt;
        int_status_r  <= int_status_nxt;
        edge_select_r <= edge_select_nxt;
        last_pads_r   <= last_pads_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_r.read_data;
  assign out_pad_drive  = out_r.pad_drive;
  assign out_pad_enable = out_r.pad_enable;
  assign out_irq_out    = out_r.irq_out;

endmodule

@@ sv/gpioei_detect.sv @@
// ----------------------------------------------------------------------------
// gpioei_detect: per-pin interrupt detection
// Compares a new pad sample with the previous one and flags every pin whose
// level or edge condition is met. All pins are checked in parallel.
// ----------------------------------------------------------------------------
module gpioei_detect #(
  parameter int PIN_COUNT = gpioei_pkg::PIN_COUNT_DEF
) (
  input  logic [31:0] pads,
  input  logic [31:0] last_pads,
  input  logic [63:0] int_config,
  input  logic [31:0] edge_select,
  output logic [31:0] hit
);

  localparam logic [31:0] PinMask = gpioei_pkg::pin_mask(PIN_COUNT);

  logic [31:0] rise;
  logic [31:0] fall;
  logic [31:0] det;

  assign rise = pads & ~last_pads;
  assign fall = ~pads & last_pads;

  always_comb begin
    for (int p = 0; p < gpioei_pkg::MAX_PINS; p++) begin
      if (edge_select[p]) begin
        det[p] = rise[p] | fall[p];
      end else begin
        case (int_config[2*p +: 2])
          gpioei_pkg::ICR_LOW:  det[p] = ~pads[p];
          gpioei_pkg::ICR_HIGH: det[p] = pads[p];
          gpioei_pkg::ICR_RISE: det[p] = rise[p];
          default:              det[p] = fall[p];
        endcase
      end
    end
  end

  // Pins beyond the port width never flag, even in low-level mode.
  assign hit = det & PinMask;

endmodule
